// ----- rtl/lfob_pkg.sv -----
// package: shared types, register map and constants of the line follow controller
`default_nettype none

package lfob_pkg;

    localparam int TIME_BITS   = 32;
    localparam int ECHO_BITS   = 15;
    localparam int DUTY_BITS   = 8;
    localparam int MS_BITS     = 16;
    localparam int ADDR_BITS   = 5;
    localparam int DATA_BITS   = 32;
    localparam int IN_BITS     = 64;
    localparam int OUT_BITS    = 32;

    localparam logic [DUTY_BITS-1:0] BYPASS_DROP = DUTY_BITS'(50);

    // direction patterns: bit0 left fwd, bit1 left back, bit2 right fwd, bit3 right back
    localparam logic [3:0] DIR_FWD   = 4'h5;
    localparam logic [3:0] DIR_BACK  = 4'hA;
    localparam logic [3:0] DIR_LEFT  = 4'h6;
    localparam logic [3:0] DIR_RIGHT = 4'h9;

    typedef enum logic [2:0] {
        MODE_FWD   = 3'd0,
        MODE_LEFT  = 3'd1,
        MODE_RIGHT = 3'd2,
        MODE_STOP  = 3'd3,
        MODE_AVOID = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        STEP_REVERSE = 3'd0,
        STEP_TURN_L  = 3'd1,
        STEP_BYPASS1 = 3'd2,
        STEP_TURN_R1 = 3'd3,
        STEP_BYPASS2 = 3'd4,
        STEP_TURN_R2 = 3'd5,
        STEP_SEARCH  = 3'd6
    } step_t;

    typedef enum logic [2:0] {
        REG_HOLDOFF  = 3'd0,
        REG_OBST     = 3'd1,
        REG_FWD_SPD  = 3'd2,
        REG_TURN_SPD = 3'd3,
        REG_REV_SPD  = 3'd4,
        REG_TURN_MS  = 3'd5,
        REG_BYPASS   = 3'd6,
        REG_SEARCH   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [MS_BITS-1:0]   holdoff_ms;
        logic [ECHO_BITS-1:0] obstacle_echo_us;
        logic [DUTY_BITS-1:0] forward_speed;
        logic [DUTY_BITS-1:0] turn_speed;
        logic [DUTY_BITS-1:0] reverse_speed;
        logic [MS_BITS-1:0]   turn_ms;
        logic [MS_BITS-1:0]   bypass_ms;
        logic [MS_BITS-1:0]   search_timeout_ms;
    } cfg_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] time_ms;
        logic                 left_line;
        logic                 right_line;
        logic [ECHO_BITS-1:0] left_echo_us;
        logic [ECHO_BITS-1:0] right_echo_us;
    } item_t;

    typedef struct packed {
        logic [DUTY_BITS-1:0] left_duty;
        logic [DUTY_BITS-1:0] right_duty;
        logic [3:0]           dir;
        mode_t                mode;
        logic [2:0]           avoid_step;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/lfob_regs.sv -----
// configuration register file behind the apb port
`default_nettype none

module lfob_regs
    import lfob_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [DATA_BITS-1:0] pwdata,
    output logic      [DATA_BITS-1:0] prdata,
    output logic                      pready,
    output cfg_t                      cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[ADDR_BITS-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_HOLDOFF:  cfg_next.holdoff_ms        = pwdata[MS_BITS-1:0];
                REG_OBST:     cfg_next.obstacle_echo_us  = pwdata[ECHO_BITS-1:0];
                REG_FWD_SPD:  cfg_next.forward_speed     = pwdata[DUTY_BITS-1:0];
                REG_TURN_SPD: cfg_next.turn_speed        = pwdata[DUTY_BITS-1:0];
                REG_REV_SPD:  cfg_next.reverse_speed     = pwdata[DUTY_BITS-1:0];
                REG_TURN_MS:  cfg_next.turn_ms           = pwdata[MS_BITS-1:0];
                REG_BYPASS:   cfg_next.bypass_ms         = pwdata[MS_BITS-1:0];
                REG_SEARCH:   cfg_next.search_timeout_ms = pwdata[MS_BITS-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_HOLDOFF:  prdata = DATA_BITS'(cfg_reg.holdoff_ms);
            REG_OBST:     prdata = DATA_BITS'(cfg_reg.obstacle_echo_us);
            REG_FWD_SPD:  prdata = DATA_BITS'(cfg_reg.forward_speed);
            REG_TURN_SPD: prdata = DATA_BITS'(cfg_reg.turn_speed);
            REG_REV_SPD:  prdata = DATA_BITS'(cfg_reg.reverse_speed);
            REG_TURN_MS:  prdata = DATA_BITS'(cfg_reg.turn_ms);
            REG_BYPASS:   prdata = DATA_BITS'(cfg_reg.bypass_ms);
            REG_SEARCH:   prdata = DATA_BITS'(cfg_reg.search_timeout_ms);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.holdoff_ms        <= MS_BITS'(100);
            cfg_reg.obstacle_echo_us  <= ECHO_BITS'(1161);
            cfg_reg.forward_speed     <= DUTY_BITS'(150);
            cfg_reg.turn_speed        <= DUTY_BITS'(90);
            cfg_reg.reverse_speed     <= DUTY_BITS'(90);
            cfg_reg.turn_ms           <= MS_BITS'(1000);
            cfg_reg.bypass_ms         <= MS_BITS'(3000);
            cfg_reg.search_timeout_ms <= MS_BITS'(5000);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/lfob_ctrl.sv -----
// mode and avoidance state machine with held motor drive registers
`default_nettype none

module lfob_ctrl
    import lfob_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic fire,
    input  item_t     item,
    input  cfg_t      cfg,
    output result_t   res_next
);

    mode_t                mode_reg, mode_next;
    step_t                step_reg, step_next;
    logic [TIME_BITS-1:0] last_change_reg, last_change_next;
    logic [TIME_BITS-1:0] step_start_reg, step_start_next;
    logic [DUTY_BITS-1:0] left_duty_reg, left_duty_next;
    logic [DUTY_BITS-1:0] right_duty_reg, right_duty_next;
    logic [3:0]           dir_reg, dir_next;

    logic                 obst;
    logic [TIME_BITS-1:0] dt_step;
    logic [TIME_BITS-1:0] dt_last;
    logic [DUTY_BITS-1:0] bypass_duty;
    mode_t                pick;

    assign obst = (item.left_echo_us != '0 && item.left_echo_us < cfg.obstacle_echo_us)
               || (item.right_echo_us != '0 && item.right_echo_us < cfg.obstacle_echo_us);
    assign dt_step = item.time_ms - step_start_reg;
    assign dt_last = item.time_ms - last_change_reg;
    assign bypass_duty = (cfg.forward_speed >= BYPASS_DROP)
                       ? cfg.forward_speed - BYPASS_DROP : '0;

    always_comb
    begin
        if (item.left_line && item.right_line && !obst)
            pick = MODE_FWD;
        else if (!item.left_line && item.right_line)
            pick = MODE_LEFT;
        else if (item.left_line && !item.right_line)
            pick = MODE_RIGHT;
        else if (obst)
            pick = MODE_AVOID;
        else
            pick = MODE_STOP;
    end

    always_comb
    begin
        mode_next        = mode_reg;
        step_next        = step_reg;
        last_change_next = last_change_reg;
        step_start_next  = step_start_reg;
        left_duty_next   = left_duty_reg;
        right_duty_next  = right_duty_reg;
        dir_next         = dir_reg;

        if (mode_reg == MODE_AVOID)
        begin
            case (step_reg)
                STEP_REVERSE:
                begin
                    left_duty_next  = cfg.reverse_speed;
                    right_duty_next = cfg.reverse_speed;
                    dir_next        = DIR_BACK;
                    if (!obst)
                    begin
                        step_next       = STEP_TURN_L;
                        step_start_next = item.time_ms;
                    end
                end
                STEP_TURN_L, STEP_TURN_R1, STEP_TURN_R2:
                begin
                    left_duty_next  = cfg.turn_speed;
                    right_duty_next = cfg.turn_speed;
                    dir_next        = (step_reg == STEP_TURN_L) ? DIR_LEFT : DIR_RIGHT;
                    if (dt_step >= TIME_BITS'(cfg.turn_ms))
                    begin
                        step_next       = step_t'(step_reg + 3'd1);
                        step_start_next = item.time_ms;
                    end
                end
                STEP_BYPASS1, STEP_BYPASS2:
                begin
                    left_duty_next  = bypass_duty;
                    right_duty_next = bypass_duty;
                    dir_next        = DIR_FWD;
                    if (dt_step >= TIME_BITS'(cfg.bypass_ms))
                    begin
                        step_next       = step_t'(step_reg + 3'd1);
                        step_start_next = item.time_ms;
                    end
                end
                STEP_SEARCH:
                begin
                    if (!item.left_line && !item.right_line)
                    begin
                        left_duty_next  = bypass_duty;
                        right_duty_next = bypass_duty;
                        dir_next        = DIR_FWD;
                        if (dt_step >= TIME_BITS'(cfg.search_timeout_ms))
                        begin
                            left_duty_next  = '0;
                            right_duty_next = '0;
                            mode_next       = MODE_STOP;
                        end
                    end
                    else
                    begin
                        mode_next = MODE_STOP;
                    end
                end
                default:
                begin
                    step_next = step_reg;
                end
            endcase
        end
        else if (dt_last >= TIME_BITS'(cfg.holdoff_ms) && pick != mode_reg)
        begin
            mode_next        = pick;
            last_change_next = item.time_ms;
            case (pick)
                MODE_FWD:
                begin
                    left_duty_next  = cfg.forward_speed;
                    right_duty_next = cfg.forward_speed;
                    dir_next        = DIR_FWD;
                end
                MODE_LEFT:
                begin
                    left_duty_next  = cfg.turn_speed;
                    right_duty_next = cfg.turn_speed;
                    dir_next        = DIR_LEFT;
                end
                MODE_RIGHT:
                begin
                    left_duty_next  = cfg.turn_speed;
                    right_duty_next = cfg.turn_speed;
                    dir_next        = DIR_RIGHT;
                end
                MODE_AVOID:
                begin
                    step_next       = STEP_REVERSE;
                    step_start_next = item.time_ms;
                end
                default:
                begin
                    left_duty_next  = '0;
                    right_duty_next = '0;
                end
            endcase
        end
    end

    assign res_next.left_duty  = left_duty_next;
    assign res_next.right_duty = right_duty_next;
    assign res_next.dir        = dir_next;
    assign res_next.mode       = mode_next;
    assign res_next.avoid_step = step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_STOP;
            step_reg        <= STEP_REVERSE;
            last_change_reg <= '0;
            step_start_reg  <= '0;
            left_duty_reg   <= '0;
            right_duty_reg  <= '0;
            dir_reg         <= '0;
        end
        else if (fire)
        begin
            mode_reg        <= mode_next;
            step_reg        <= step_next;
            last_change_reg <= last_change_next;
            step_start_reg  <= step_start_next;
            left_duty_reg   <= left_duty_next;
            right_duty_reg  <= right_duty_next;
            dir_reg         <= dir_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/line_follow_obstacle_bypass_fsm_unit.sv -----
// top level: stream ports, input and result registers, config port
// path: an input transaction is held in the input register, then its result in the result register with tvalid
// throughput: one transaction per cycle while m_axis_tready holds, set by the single state update stage
// the input register still takes one transaction while a result waits, then tready drops
// reset: asynchronous active low; mode stopped, motors off, registers at defaults
`default_nettype none

module line_follow_obstacle_bypass_fsm_unit
    import lfob_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // time_ms[31:0], left_line[32], right_line[33], left_echo_us[48:34], right_echo_us[63:49]
    input  wire logic [IN_BITS-1:0]   s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // left_duty[7:0], right_duty[15:8], left_fwd[16], left_back[17], right_fwd[18],
    // right_back[19], mode[22:20], avoid_step[25:23], zero pad[31:26]
    output logic      [OUT_BITS-1:0]  m_axis_tdata,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [DATA_BITS-1:0] pwdata,
    output logic      [DATA_BITS-1:0] prdata,
    output logic                      pready
);

    cfg_t    cfg;
    item_t   in_item_reg, in_item_next;
    logic    in_valid_reg, in_valid_next;
    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg, out_res_next;
    result_t res_next;
    logic    s_fire;
    logic    advance;

    lfob_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lfob_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (advance),
        .item     (in_item_reg),
        .cfg      (cfg),
        .res_next (res_next)
    );

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_item_next  = in_item_reg;
        in_valid_next = in_valid_reg;
        if (s_fire)
        begin
            in_item_next.time_ms       = s_axis_tdata[31:0];
            in_item_next.left_line     = s_axis_tdata[32];
            in_item_next.right_line    = s_axis_tdata[33];
            in_item_next.left_echo_us  = s_axis_tdata[48:34];
            in_item_next.right_echo_us = s_axis_tdata[63:49];
            in_valid_next              = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_res_next   = out_res_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_res_next   = res_next;
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_item_reg <= in_item_next;
        out_res_reg <= out_res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_res_reg.avoid_step, out_res_reg.mode,
                            out_res_reg.dir, out_res_reg.right_duty, out_res_reg.left_duty};

endmodule

`default_nettype wire
